// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define SPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spq check failed");

// Same, with a message of its own.
`define SPQ_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Types and constants of the sorted-array priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OUT_CNT_W = 5;
  localparam logic [OUT_CNT_W-1:0] FULL_COUNT = OUT_CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    logic signed [31:0]     out_value;
    logic signed [31:0]     out_priority;
    status_e                status;
    logic [OUT_CNT_W-1:0]   count;
  } res_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // Per-cell command for the cycle.
  typedef struct packed {
    logic insert;  // enqueue taken
    logic shift;   // dequeue taken
  } cell_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: compares, holds, takes the new entry, or takes from a neighbor.
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occ_i,        // slot holds an entry
  input  entry_t    new_i,        // entry being enqueued
  input  logic      left_keep_i,  // left neighbor stays put on insert
  input  entry_t    left_i,
  input  entry_t    right_i,
  output logic      keep_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  // Entry stays ahead of the new one when its priority is not larger.
  assign keep_o  = occ_i && (entry_q.prio <= new_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert && !keep_o) begin
      entry_d = left_keep_i ? new_i : left_i;
    end else if (cmd_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/sorted_array_priority_queue_top.sv =====
// Top level of the sorted-array priority queue built as a chain of cells.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive req_i and raise start; the command transfers at
//   the rising edge where start is high and busy is low. busy stays low, so
//   a command may transfer in every cycle.
//   Result channel: done_o pulses for one cycle, in the cycle after the command
//   transferred, with res_o valid in that cycle. There is no back pressure:
//   the receiver must take the result in that cycle.
//   Operations: enqueue inserts behind all entries of equal or smaller
//   priority (oldest first among equals); dequeue returns and removes the
//   front; peek returns the front. Empty queue gives status empty, an
//   enqueue into a full queue is dropped with status full. Op code 3 does
//   nothing and reports the count.
//   Rate: one command per cycle. Every cell compares its own priority with
//   the incoming one in parallel, so the single 32-bit compare per cell
//   sets the cycle time, not the depth.
//   Reset: rst_ni clears the entry count and the result strobe; slot
//   contents are left as they are and never read until written.
module sorted_array_priority_queue_top import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  logic             accept;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  res_t             res_q, res_d;
  cell_cmd_t        cmd;
  entry_t           new_entry;
  entry_t           cells [DEPTH];
  logic             keep  [DEPTH];
  logic             full, empty;
  logic [CNT_W+OUT_CNT_W-1:0] count_wide;

  // Busy is never raised: every command completes without a stall.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign new_entry.value = req_i.item_value;
  assign new_entry.prio  = req_i.item_priority;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Decode the command and build the result.
  always_comb begin
    cmd              = '0;
    count_d          = count_q;
    res_d.out_value  = '0;
    res_d.out_priority = '0;
    res_d.status     = ST_OK;
    case (req_i.op)
      OP_ENQ: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          cmd.insert = accept;
          count_d    = count_q + 1'b1;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          cmd.shift          = accept;
          res_d.out_value    = cells[0].value;
          res_d.out_priority = cells[0].prio;
          count_d            = count_q - 1'b1;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.out_value    = cells[0].value;
          res_d.out_priority = cells[0].prio;
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
    count_wide  = {{OUT_CNT_W{1'b0}}, count_d};
    res_d.count = count_wide[OUT_CNT_W-1:0];
  end

  // Chain of cells, slot 0 at the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_keep;
    entry_t left_e;
    entry_t right_e;

    assign occ = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_e    = new_entry;
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_e    = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cells[i];
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ),
      .new_i       (new_entry),
      .left_keep_i (left_keep),
      .left_i      (left_e),
      .right_i     (right_e),
      .keep_o      (keep[i]),
      .entry_o     (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks on the priority queue top, bound to it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spq_checker import spq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input res_t res_o
);

  // Every transfer in gives a result in the next cycle, and only then.
  `SPQ_ASSERT(a_result_follows, (start && !busy) |=> done_o)
  `SPQ_ASSERT(a_no_spurious, done_o |-> $past(start && !busy))
  // Empty status only with nothing held; full only at capacity.
  `SPQ_ASSERT_MSG(a_empty_count, (done_o && res_o.status == ST_EMPTY) |-> (res_o.count == '0), "empty with entries")
  `SPQ_ASSERT_MSG(a_full_count, (done_o && res_o.status == ST_FULL) |-> (res_o.count == FULL_COUNT), "full below capacity")

endmodule

bind sorted_array_priority_queue_top spq_checker u_spq_checker (.*);
